### hdl/aabb_collision_table_unit_defines.svh
// ----------------------------------------------------------------------------
// aabb_collision_table_unit_defines.svh
// Assertion macros shared by the checker of the collision table unit.
// ----------------------------------------------------------------------------
`ifndef AABB_COLLISION_TABLE_UNIT_DEFINES_SVH
`define AABB_COLLISION_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define AABB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define AABB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/aabb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pkg
// Constants, types and overlap functions of the rectangle collision table.
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int COORD_BITS  = 16;
   localparam int SIZE_BITS   = COORD_BITS - 1;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int OUT_IDX_W   = 5;
   localparam int WIDE_W      = COORD_BITS + 2;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_FLUSH  = 2'd3;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [SIZE_BITS-1:0]  size_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;
   typedef logic        [IDX_W-1:0]      idx_type;
   typedef logic        [CNT_W-1:0]      cnt_type;
   typedef logic        [OUT_IDX_W-1:0]  out_idx_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      size_type  w;
      size_type  h;
   } rect_type;

   localparam int RECT_W = $bits(rect_type);

   function automatic wide_type widen_c(input coord_type v);
      return WIDE_W'(v);
   endfunction

   function automatic wide_type widen_s(input size_type v);
      return $signed(WIDE_W'(v));
   endfunction

   // Inclusive overlap on both axes.
   function automatic logic overlap(input rect_type a, input rect_type b);
      wide_type ax, ay, bx, by, ax2, ay2, bx2, by2;
      ax  = widen_c(a.x);
      ay  = widen_c(a.y);
      bx  = widen_c(b.x);
      by  = widen_c(b.y);
      ax2 = ax + widen_s(a.w);
      ay2 = ay + widen_s(a.h);
      bx2 = bx + widen_s(b.w);
      by2 = by + widen_s(b.h);
      return (ax2 >= bx) && (bx2 >= ax) && (ay2 >= by) && (by2 >= ay);
   endfunction

   // Strict containment of a point.
   function automatic logic contains(input coord_type px, input coord_type py,
                                     input rect_type b);
      wide_type x, y, bx, by;
      x  = widen_c(px);
      y  = widen_c(py);
      bx = widen_c(b.x);
      by = widen_c(b.y);
      return (x > bx) && (x < bx + widen_s(b.w)) &&
             (y > by) && (y < by + widen_s(b.h));
   endfunction

   function automatic out_idx_type to_out_idx(input idx_type v);
      return OUT_IDX_W'(v);
   endfunction

endpackage

### hdl/aabb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module aabb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/aabb_collision_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_collision_table_unit
// Table of axis-aligned rectangles with an all-pairs overlap tick and a
// point query, built around one rectangle RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (opcode, position, size); it is taken when
//   req_valid is high and req_stall is low. req_stall stays high while a
//   tick or a query is in progress, so one item is worked on at a time.
//   Append and flush finish in the accept cycle and give no result.
//   rsp_* carries results out of an output register; it advances when
//   rsp_valid is high and rsp_stall is low. A stalled result holds, and the
//   sequencer waits in its emit step until the register frees up.
//   Tick on N entries: per entry the sequencer fetches it, streams all
//   entries past it through the single RAM read port, one at a time,
//   drains and emits. One result per entry, in index order, last set
//   on the final one; an empty table gives none.
//   Query on N entries: a scan of all N entries, a drain and the emit;
//   one result, last set.
//   Reset clears the entry count, the sequencer and the output register;
//   the RAM contents are not cleared and only entries below the count are
//   ever read.
// ----------------------------------------------------------------------------
module aabb_collision_table_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_opcode,
   input  logic signed [aabb_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [aabb_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic [aabb_pkg::SIZE_BITS-1:0]         req_size_w,
   input  logic [aabb_pkg::SIZE_BITS-1:0]         req_size_h,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_result_kind,
   output logic [aabb_pkg::OUT_IDX_W-1:0]         rsp_entry_index,
   output logic                                   rsp_colliding,
   output logic                                   rsp_partner_valid,
   output logic [aabb_pkg::OUT_IDX_W-1:0]         rsp_partner_index,
   output logic                                   rsp_hit_found,
   output logic [aabb_pkg::OUT_IDX_W-1:0]         rsp_hit_index,
   output logic                                   rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_A,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                  state_ff;
   aabb_pkg::cnt_type          count_ff;
   aabb_pkg::idx_type          i_ff;       // entry under test (tick)
   aabb_pkg::idx_type          j_ff;       // entry being fetched
   aabb_pkg::idx_type          jd_ff;      // entry whose data is on the read port
   logic                       tick_mode_ff;
   logic                       cap_a_ff;   // read data is entry i: capture it
   logic                       chk_ff;     // read data is entry jd: compare it
   aabb_pkg::rect_type         a_ff;       // entry i, or the query point
   logic                       col_ff;
   aabb_pkg::idx_type          part_ff;
   logic                       found_ff;
   aabb_pkg::idx_type          hit_ff;

   // output register
   logic                       rsp_valid_ff;
   logic                       rsp_kind_ff;
   aabb_pkg::out_idx_type      rsp_entry_ff;
   logic                       rsp_col_ff;
   aabb_pkg::out_idx_type      rsp_part_ff;
   logic                       rsp_found_ff;
   aabb_pkg::out_idx_type      rsp_hit_ff;
   logic                       rsp_last_ff;

   logic                       req_accept;
   logic                       table_full;
   logic                       append_we;
   logic                       out_free;
   aabb_pkg::cnt_type          cnt_m1;
   aabb_pkg::idx_type          last_idx;
   aabb_pkg::idx_type          rd_addr;
   logic [aabb_pkg::RECT_W-1:0] rd_data;
   aabb_pkg::rect_type         rd_rect;
   aabb_pkg::rect_type         wr_rect;
   logic                       pair_hit;
   logic                       query_hit;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign table_full = (count_ff >= aabb_pkg::CNT_W'(aabb_pkg::MAX_ENTRIES));
   assign append_we  = req_accept && (req_opcode == aabb_pkg::OP_APPEND) && !table_full;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cnt_m1     = count_ff - aabb_pkg::CNT_W'(1);
   assign last_idx   = cnt_m1[aabb_pkg::IDX_W-1:0];

   // Fetch entry i first, then stream every entry past it.
   assign rd_addr = (state_ff == ST_LOAD_A) ? i_ff : j_ff;

   always_comb begin
      wr_rect.x = req_pos_x;
      wr_rect.y = req_pos_y;
      wr_rect.w = req_size_w;
      wr_rect.h = req_size_h;
   end

   aabb_ram #(
      .WIDTH (aabb_pkg::RECT_W),
      .DEPTH (aabb_pkg::MAX_ENTRIES)
   ) u_rect_ram (
      .clock   (clock),
      .wr_en   (append_we),
      .wr_addr (count_ff[aabb_pkg::IDX_W-1:0]),
      .wr_data (wr_rect),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rect = rd_data;

   // Compare the held entry (or point) against the streamed entry.
   assign pair_hit  = chk_ff && tick_mode_ff && (jd_ff != i_ff) &&
                      aabb_pkg::overlap(a_ff, rd_rect);
   assign query_hit = chk_ff && !tick_mode_ff && !found_ff &&
                      aabb_pkg::contains(a_ff.x, a_ff.y, rd_rect);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_a_ff     <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop a result once the receiver takes it
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cap_a_ff) begin
            a_ff <= rd_rect;
         end

         // largest overlapping index wins: later j overwrites
         if (pair_hit) begin
            col_ff  <= 1'b1;
            part_ff <= jd_ff;
         end
         // lowest containing index wins: keep the first one
         if (query_hit) begin
            found_ff <= 1'b1;
            hit_ff   <= jd_ff;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  case (req_opcode)
                     aabb_pkg::OP_APPEND: begin
                        if (!table_full) begin
                           count_ff <= count_ff + aabb_pkg::CNT_W'(1);
                        end
                     end
                     aabb_pkg::OP_FLUSH: begin
                        count_ff <= '0;
                     end
                     aabb_pkg::OP_TICK: begin
                        tick_mode_ff <= 1'b1;
                        i_ff         <= '0;
                        if (count_ff != '0) begin
                           state_ff <= ST_LOAD_A;
                        end
                     end
                     default: begin
                        // point query
                        tick_mode_ff <= 1'b0;
                        a_ff.x       <= req_pos_x;
                        a_ff.y       <= req_pos_y;
                        found_ff     <= 1'b0;
                        hit_ff       <= '0;
                        j_ff         <= '0;
                        chk_ff       <= 1'b0;
                        if (count_ff == '0) begin
                           state_ff <= ST_EMIT;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                  endcase
               end
            end
            ST_LOAD_A: begin
               col_ff   <= 1'b0;
               part_ff  <= '0;
               j_ff     <= '0;
               cap_a_ff <= 1'b1;
               chk_ff   <= 1'b0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               cap_a_ff <= 1'b0;
               chk_ff   <= 1'b1;
               jd_ff    <= j_ff;
               if (j_ff == last_idx) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  j_ff <= j_ff + aabb_pkg::IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               chk_ff   <= 1'b0;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (tick_mode_ff) begin
                     rsp_kind_ff  <= aabb_pkg::KIND_TICK;
                     rsp_entry_ff <= aabb_pkg::to_out_idx(i_ff);
                     rsp_col_ff   <= col_ff;
                     rsp_part_ff  <= aabb_pkg::to_out_idx(part_ff);
                     rsp_found_ff <= 1'b0;
                     rsp_hit_ff   <= '0;
                     rsp_last_ff  <= (i_ff == last_idx);
                     if (i_ff == last_idx) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        i_ff     <= i_ff + aabb_pkg::IDX_W'(1);
                        state_ff <= ST_LOAD_A;
                     end
                  end else begin
                     rsp_kind_ff  <= aabb_pkg::KIND_QUERY;
                     rsp_entry_ff <= '0;
                     rsp_col_ff   <= 1'b0;
                     rsp_part_ff  <= '0;
                     rsp_found_ff <= found_ff;
                     rsp_hit_ff   <= aabb_pkg::to_out_idx(hit_ff);
                     rsp_last_ff  <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_entry_index   = rsp_entry_ff;
   assign rsp_colliding     = rsp_col_ff;
   assign rsp_partner_valid = rsp_col_ff;
   assign rsp_partner_index = rsp_part_ff;
   assign rsp_hit_found     = rsp_found_ff;
   assign rsp_hit_index     = rsp_hit_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

### hdl/aabb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_checker
// Port-level checks of the collision table unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "aabb_collision_table_unit_defines.svh"

module aabb_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic                                   rsp_result_kind,
   input logic [aabb_pkg::OUT_IDX_W-1:0]         rsp_entry_index,
   input logic                                   rsp_colliding,
   input logic                                   rsp_partner_valid,
   input logic [aabb_pkg::OUT_IDX_W-1:0]         rsp_partner_index,
   input logic                                   rsp_hit_found,
   input logic [aabb_pkg::OUT_IDX_W-1:0]         rsp_hit_index,
   input logic                                   rsp_last
);

   // hold a stalled result
   `AABB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_entry_index) && $stable(rsp_partner_index) && $stable(rsp_last), "stalled result changed")

   // a query result is the last one, with entry index zero and no collision
   `AABB_ASSERT_NOW(a_query_last, rsp_valid && (rsp_result_kind == aabb_pkg::KIND_QUERY), rsp_last && (rsp_entry_index == '0) && !rsp_colliding, "query result malformed")

   // tick results carry no hit, and partner validity follows the flag
   `AABB_ASSERT_NOW(a_tick_fields, rsp_valid && (rsp_result_kind == aabb_pkg::KIND_TICK), !rsp_hit_found && (rsp_hit_index == '0) && (rsp_partner_valid == rsp_colliding), "tick result malformed")

   // an entry never reports itself as its partner
   `AABB_ASSERT_NOW(a_no_self, rsp_valid && (rsp_result_kind == aabb_pkg::KIND_TICK) && rsp_colliding, rsp_partner_index != rsp_entry_index, "entry paired with itself")

endmodule

bind aabb_collision_table_unit aabb_checker u_aabb_checker (.*);
